/* src/atdf_pkg.sv */
// shared constants, types and pointer helpers for the at-frame byte deframer
package atdf_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int FRAME_BYTES = 17;
    localparam int ID_SHIFT    = 3;

    localparam logic [7:0] MARK_A  = 8'h41;
    localparam logic [7:0] MARK_T  = 8'h54;
    localparam logic [7:0] MARK_CR = 8'h0D;
    localparam logic [7:0] MARK_LF = 8'h0A;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [PTR_W:0]   ptr_sum_t;

    // circular add, works for any depth
    function automatic ptr_t wrap_add(input ptr_t p, input ptr_t k);
        ptr_sum_t s;
        s = {1'b0, p} + {1'b0, k};
        if (s >= ptr_sum_t'(STORE_DEPTH))
        begin
            s = s - ptr_sum_t'(STORE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // number of stored bytes between the pointers
    function automatic ptr_t fill_of(input ptr_t wp, input ptr_t rp);
        ptr_sum_t s;
        if (wp >= rp)
        begin
            s = {1'b0, wp} - {1'b0, rp};
        end
        else
        begin
            s = {1'b0, wp} + ptr_sum_t'(STORE_DEPTH) - {1'b0, rp};
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* src/atdf_ram.sv */
// generic single write port, single read port ram with registered read
module atdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/at_frame_byte_deframer.sv */
// at-frame deframer: circular byte store with a serial frame search
// byte word (op 0): written to the store at once unless the store is full, gives no result
// frame request (op 1): one store byte read per cycle through a 17-byte window; the result is
//   loaded on a hit or once every stored byte is seen, when the output slot is free
// input stalls until the scan ends, so a request is taken only after the last result is loaded;
//   a waiting result holds only the end of the next scan
// reset (rst_n, async, active low) empties the store; store contents stay unwritten
module at_frame_byte_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [28:0] ident,
    output logic [7:0]  length_byte,
    output logic [31:0] data_low,
    output logic [31:0] data_high
);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;

    // store pointers
    atdf_pkg::ptr_t rd_ptr_reg, rd_ptr_next;
    atdf_pkg::ptr_t wr_ptr_reg, wr_ptr_next;

    // scan bookkeeping: bytes available, reads issued, bytes shifted into the window
    atdf_pkg::ptr_t avail_reg, avail_next;
    atdf_pkg::ptr_t issue_cnt_reg, issue_cnt_next;
    atdf_pkg::ptr_t load_cnt_reg, load_cnt_next;
    logic           rd_vld_reg, rd_vld_next;

    // sliding window, element 0 is the oldest byte
    logic [7:0] win_reg [atdf_pkg::FRAME_BYTES];
    logic       win_shift;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        found_reg;
    logic [28:0] ident_reg;
    logic [7:0]  length_reg;
    logic [31:0] data_low_reg;
    logic [31:0] data_high_reg;
    logic        out_load;

    logic           in_accept;
    logic           store_full;
    logic           ram_we;
    atdf_pkg::ptr_t ram_raddr;
    logic [7:0]     ram_rdata;
    logic           issue;
    logic           match;
    logic           exhausted;
    logic           slot_free;
    logic [31:0]    hdr_word;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign store_full = (atdf_pkg::fill_of(wr_ptr_reg, rd_ptr_reg)
                         == atdf_pkg::PTR_W'(atdf_pkg::STORE_DEPTH - 1));

    // a byte word goes straight into the store unless it is full
    assign ram_we = in_accept && (op == atdf_pkg::OP_BYTE) && !store_full;

    // read one byte ahead of the window while bytes remain
    assign issue     = (state_reg == ST_SCAN) && (issue_cnt_reg != avail_reg);
    assign ram_raddr = atdf_pkg::wrap_add(rd_ptr_reg, issue_cnt_reg);

    atdf_ram #(
        .WIDTH (8),
        .DEPTH (atdf_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window holds a full frame candidate once 17 bytes are in
    assign match = (load_cnt_reg >= atdf_pkg::PTR_W'(atdf_pkg::FRAME_BYTES))
                && (win_reg[0] == atdf_pkg::MARK_A)
                && (win_reg[1] == atdf_pkg::MARK_T)
                && (win_reg[atdf_pkg::FRAME_BYTES-2] == atdf_pkg::MARK_CR)
                && (win_reg[atdf_pkg::FRAME_BYTES-1] == atdf_pkg::MARK_LF);

    // every stored byte seen without a hit
    assign exhausted = (load_cnt_reg == avail_reg);

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_SCAN) && (match || exhausted) && slot_free;

    // window freezes on a hit so the fields stay put while the output slot is busy
    assign win_shift = (state_reg == ST_SCAN) && rd_vld_reg && !match && !exhausted;

    assign hdr_word = {win_reg[2], win_reg[3], win_reg[4], win_reg[5]};

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        avail_next     = avail_reg;
        issue_cnt_next = issue_cnt_reg;
        load_cnt_next  = load_cnt_reg;
        rd_vld_next    = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (ram_we)
        begin
            wr_ptr_next = atdf_pkg::wrap_add(wr_ptr_reg, atdf_pkg::PTR_W'(1));
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (op == atdf_pkg::OP_REQUEST))
                begin
                    state_next     = ST_SCAN;
                    avail_next     = atdf_pkg::fill_of(wr_ptr_reg, rd_ptr_reg);
                    issue_cnt_next = '0;
                    load_cnt_next  = '0;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = issue;
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + atdf_pkg::PTR_W'(1);
                end
                if (win_shift)
                begin
                    load_cnt_next = load_cnt_reg + atdf_pkg::PTR_W'(1);
                end
                if (out_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    // consume skipped bytes plus the frame itself
                    if (match)
                    begin
                        rd_ptr_next = atdf_pkg::wrap_add(rd_ptr_reg, load_cnt_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            avail_reg     <= '0;
            issue_cnt_reg <= '0;
            load_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            avail_reg     <= avail_next;
            issue_cnt_reg <= issue_cnt_next;
            load_cnt_reg  <= load_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window shift line, newest byte enters at the top
    always_ff @(posedge clk)
    begin
        if (win_shift)
        begin
            for (int i = 0; i < atdf_pkg::FRAME_BYTES - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[atdf_pkg::FRAME_BYTES-1] <= ram_rdata;
        end
    end

    // result fields, zero when no frame was found
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg <= match;
            if (match)
            begin
                ident_reg     <= hdr_word[31:atdf_pkg::ID_SHIFT];
                length_reg    <= win_reg[6];
                data_low_reg  <= {win_reg[10], win_reg[9], win_reg[8], win_reg[7]};
                data_high_reg <= {win_reg[14], win_reg[13], win_reg[12], win_reg[11]};
            end
            else
            begin
                ident_reg     <= '0;
                length_reg    <= '0;
                data_low_reg  <= '0;
                data_high_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign ident       = ident_reg;
    assign length_byte = length_reg;
    assign data_low    = data_low_reg;
    assign data_high   = data_high_reg;

endmodule
